@@ src/size_class_pool_allocator_core_defines.svh @@
// assertion macros shared by the checker
`ifndef SIZE_CLASS_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SCPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/scpa_pkg.sv @@
`timescale 1ns / 1ps
package scpa_pkg;

   localparam int CLASS_COUNT = 12;
   localparam logic [3:0] NO_CLASS = 4'd12;
   localparam int ARENA_AW = 17;
   localparam logic [20:0] ARENA_END = 21'h100000;
   localparam logic [20:0] BUMP_RESET = 21'd8;
   localparam logic [16:0] SLAB_RESET = 17'd16384;
   localparam logic [31:0] TAG_MAGIC = 32'hC0FFEE00;
   localparam logic [31:0] TAG_MASK = 32'hFFFFFF00;
   localparam int DIV_STEPS = 17;
   localparam logic [9:0] COPY_CAP = 10'd512;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_REALLOC = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EXHAUSTED = 2'd1,
      STAT_BIG       = 2'd2,
      STAT_FOREIGN   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_OWN_RD, ST_OWN_CHK, ST_TAKE, ST_TAKE_CHK, ST_DIV,
      ST_MUL, ST_FIT, ST_CARVE_H, ST_CARVE_L, ST_POP_RD, ST_POP, ST_GIVE, ST_FIN
   } state_type;

   typedef struct packed {
      logic                en;
      logic [ARENA_AW-1:0] addr;
      logic [63:0]         data;
   } arena_wr_type;

   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [9:0]  divisor;
   } div_req_type;

   function automatic logic [9:0] class_bytes(input logic [3:0] idx);
      logic [9:0] r;
      unique case (idx)
         4'd0:    r = 10'd16;
         4'd1:    r = 10'd24;
         4'd2:    r = 10'd32;
         4'd3:    r = 10'd48;
         4'd4:    r = 10'd64;
         4'd5:    r = 10'd96;
         4'd6:    r = 10'd128;
         4'd7:    r = 10'd160;
         4'd8:    r = 10'd192;
         4'd9:    r = 10'd256;
         4'd10:   r = 10'd384;
         default: r = 10'd512;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pick_class(input logic [15:0] n);
      logic [3:0] r;
      r = NO_CLASS;
      for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
         if ({6'd0, class_bytes(4'(i))} >= n) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ src/size_class_pool_allocator_core.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  mode, pointer, request_size
// rsp_      out        rsp_valid/rsp_stall  result_pointer, size_class, copy_length, status
// csr_      in         csr_valid/csr_ready  slab_bytes
//
// a refill runs the divider, then writes a header and a link word per carved block (one arena write port)
// one transaction in flight; req_stall is high from accept until the result is registered
// the result register lets the next request in while rsp_stall holds the previous result
// synchronous reset empties all class lists, bump pointer to 8, slab_bytes to 16384
module size_class_pool_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [19:0] req_pointer,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [19:0] rsp_result_pointer,
   output logic [3:0]  rsp_size_class,
   output logic [9:0]  rsp_copy_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_slab_bytes
);

   scpa_pkg::state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [19:0] ptr_ff, ptr_in;
   logic [15:0] size_ff, size_in;
   logic        move_ff, move_in;
   logic [3:0]  c_ff, c_in;
   logic [3:0]  oc_ff, oc_in;
   logic [15:0] old_ff, old_in;
   logic [19:0] heads_ff [scpa_pkg::CLASS_COUNT];
   logic        head_we;
   logic [19:0] head_wdata;
   logic [3:0]  head_idx;
   logic [19:0] head_rd;
   logic [20:0] bump_ff, bump_in;
   logic [16:0] slab_ff;
   logic [16:0] cnt_ff, cnt_in;
   logic [16:0] i_ff, i_in;
   logic [20:0] h_ff, h_in;
   logic [26:0] need_ff, need_in;
   logic [9:0]  stride_ff, stride_in;
   logic [1:0]  st_ff, st_in;
   logic [19:0] rptr_ff, rptr_in;
   logic [3:0]  rcls_ff, rcls_in;
   logic [9:0]  copy_ff, copy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_ptr_ff, rsp_ptr_in;
   logic [3:0]  rsp_cls_ff, rsp_cls_in;
   logic [9:0]  rsp_copy_ff, rsp_copy_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;

   scpa_pkg::arena_wr_type        arena_wr;
   logic [scpa_pkg::ARENA_AW-1:0] arena_raddr;
   logic [63:0]                   arena_rdata;
   scpa_pkg::div_req_type         div_req;
   logic                          div_done;
   logic [16:0]                   div_q;

   logic [15:0] n1;
   logic [3:0]  nc;
   logic [15:0] copy_min;
   logic [20:0] h_next;

   scpa_arena u_arena (
      .clock (clock),
      .wr    (arena_wr),
      .raddr (arena_raddr),
      .rdata (arena_rdata)
   );

   scpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign head_idx = (state_ff == scpa_pkg::ST_GIVE) ? oc_ff : c_ff;
   assign head_rd  = heads_ff[head_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpa_pkg::ST_IDLE;
         bump_ff      <= scpa_pkg::BUMP_RESET;
         slab_ff      <= scpa_pkg::SLAB_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < scpa_pkg::CLASS_COUNT; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            slab_ff <= csr_slab_bytes;
         end
         if (head_we) begin
            heads_ff[head_idx] <= head_wdata;
         end
      end
      mode_ff     <= mode_in;
      ptr_ff      <= ptr_in;
      size_ff     <= size_in;
      move_ff     <= move_in;
      c_ff        <= c_in;
      oc_ff       <= oc_in;
      old_ff      <= old_in;
      cnt_ff      <= cnt_in;
      i_ff        <= i_in;
      h_ff        <= h_in;
      need_ff     <= need_in;
      stride_ff   <= stride_in;
      st_ff       <= st_in;
      rptr_ff     <= rptr_in;
      rcls_ff     <= rcls_in;
      copy_ff     <= copy_in;
      rsp_ptr_ff  <= rsp_ptr_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_copy_ff <= rsp_copy_in;
      rsp_st_ff   <= rsp_st_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      size_in      = size_ff;
      move_in      = move_ff;
      c_in         = c_ff;
      oc_in        = oc_ff;
      old_in       = old_ff;
      bump_in      = bump_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      h_in         = h_ff;
      need_in      = need_ff;
      stride_in    = stride_ff;
      st_in        = st_ff;
      rptr_in      = rptr_ff;
      rcls_in      = rcls_ff;
      copy_in      = copy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_copy_in  = rsp_copy_ff;
      rsp_st_in    = rsp_st_ff;
      head_we      = 1'b0;
      head_wdata   = '0;
      arena_wr     = '0;
      arena_raddr  = '0;
      div_req      = '0;
      n1           = (size_ff == 16'd0) ? 16'd1 : size_ff;
      nc           = scpa_pkg::pick_class(size_ff);
      copy_min     = (old_ff < size_ff) ? old_ff : size_ff;
      h_next       = h_ff + {11'd0, stride_ff};

      unique case (state_ff)
         scpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               ptr_in   = req_pointer;
               size_in  = req_request_size;
               move_in  = 1'b0;
               st_in    = scpa_pkg::STAT_OK;
               rptr_in  = '0;
               rcls_in  = scpa_pkg::NO_CLASS;
               copy_in  = '0;
               state_in = scpa_pkg::ST_DECODE;
            end
         end
         scpa_pkg::ST_DECODE: begin
            unique case (scpa_pkg::mode_type'(mode_ff))
               scpa_pkg::MODE_ALLOC:   state_in = scpa_pkg::ST_TAKE;
               scpa_pkg::MODE_FREE:    state_in = (ptr_ff == 20'd0) ? scpa_pkg::ST_FIN
                                                                    : scpa_pkg::ST_OWN_RD;
               scpa_pkg::MODE_REALLOC: state_in = (ptr_ff == 20'd0) ? scpa_pkg::ST_TAKE
                                                                    : scpa_pkg::ST_OWN_RD;
               default:                state_in = scpa_pkg::ST_FIN;
            endcase
         end
         scpa_pkg::ST_OWN_RD: begin
            if (ptr_ff[19:3] == 17'd0 || ptr_ff[2:0] != 3'd0) begin
               st_in    = scpa_pkg::STAT_FOREIGN;
               state_in = scpa_pkg::ST_FIN;
            end else begin
               arena_raddr = ptr_ff[19:3] - 17'd1;
               state_in    = scpa_pkg::ST_OWN_CHK;
            end
         end
         scpa_pkg::ST_OWN_CHK: begin
            if ((arena_rdata[31:0] & scpa_pkg::TAG_MASK) != scpa_pkg::TAG_MAGIC ||
                arena_rdata[7:0] >= 8'(scpa_pkg::CLASS_COUNT)) begin
               st_in    = scpa_pkg::STAT_FOREIGN;
               state_in = scpa_pkg::ST_FIN;
            end else begin
               oc_in  = arena_rdata[3:0];
               old_in = arena_rdata[47:32];
               if (mode_ff == scpa_pkg::MODE_FREE || size_ff == 16'd0) begin
                  state_in = scpa_pkg::ST_GIVE;
               end else if (nc == arena_rdata[3:0]) begin
                  arena_wr.en   = 1'b1;
                  arena_wr.addr = ptr_ff[19:3] - 17'd1;
                  arena_wr.data = {16'd0, size_ff, arena_rdata[31:0]};
                  rptr_in       = ptr_ff;
                  rcls_in       = arena_rdata[3:0];
                  state_in      = scpa_pkg::ST_FIN;
               end else if (nc == scpa_pkg::NO_CLASS) begin
                  st_in    = scpa_pkg::STAT_BIG;
                  state_in = scpa_pkg::ST_FIN;
               end else begin
                  move_in  = 1'b1;
                  state_in = scpa_pkg::ST_TAKE;
               end
            end
         end
         scpa_pkg::ST_TAKE: begin
            c_in = scpa_pkg::pick_class(n1);
            if (c_in == scpa_pkg::NO_CLASS) begin
               st_in    = scpa_pkg::STAT_BIG;
               state_in = scpa_pkg::ST_FIN;
            end else begin
               state_in = scpa_pkg::ST_TAKE_CHK;
            end
         end
         scpa_pkg::ST_TAKE_CHK: begin
            if (head_rd == 20'd0) begin
               stride_in        = 10'd8 + scpa_pkg::class_bytes(c_ff);
               div_req.start    = 1'b1;
               div_req.dividend = slab_ff;
               div_req.divisor  = stride_in;
               state_in         = scpa_pkg::ST_DIV;
            end else begin
               state_in = scpa_pkg::ST_POP_RD;
            end
         end
         scpa_pkg::ST_DIV: begin
            if (div_done) begin
               cnt_in   = (div_q == 17'd0) ? 17'd1 : div_q;
               state_in = scpa_pkg::ST_MUL;
            end
         end
         scpa_pkg::ST_MUL: begin
            need_in  = 27'(cnt_ff * stride_ff);
            state_in = scpa_pkg::ST_FIT;
         end
         scpa_pkg::ST_FIT: begin
            if (bump_ff > scpa_pkg::ARENA_END ||
                need_ff > 27'(scpa_pkg::ARENA_END) - 27'(bump_ff)) begin
               st_in    = scpa_pkg::STAT_EXHAUSTED;
               state_in = scpa_pkg::ST_FIN;
            end else begin
               h_in     = bump_ff;
               i_in     = '0;
               state_in = scpa_pkg::ST_CARVE_H;
            end
         end
         scpa_pkg::ST_CARVE_H: begin
            arena_wr.en   = 1'b1;
            arena_wr.addr = h_ff[19:3];
            arena_wr.data = {32'd0, scpa_pkg::TAG_MAGIC | {28'd0, c_ff}};
            state_in      = scpa_pkg::ST_CARVE_L;
         end
         scpa_pkg::ST_CARVE_L: begin
            arena_wr.en   = 1'b1;
            arena_wr.addr = h_ff[19:3] + 17'd1;
            arena_wr.data = {44'd0, head_rd};
            head_we       = 1'b1;
            head_wdata    = h_ff[19:0] + 20'd8;
            h_in          = h_next;
            i_in          = i_ff + 17'd1;
            if (i_in == cnt_ff) begin
               bump_in  = h_next;
               state_in = scpa_pkg::ST_POP_RD;
            end else begin
               state_in = scpa_pkg::ST_CARVE_H;
            end
         end
         scpa_pkg::ST_POP_RD: begin
            arena_raddr = head_rd[19:3];
            state_in    = scpa_pkg::ST_POP;
         end
         scpa_pkg::ST_POP: begin
            head_we       = 1'b1;
            head_wdata    = arena_rdata[19:0];
            arena_wr.en   = 1'b1;
            arena_wr.addr = head_rd[19:3] - 17'd1;
            arena_wr.data = {16'd0, n1, scpa_pkg::TAG_MAGIC | {28'd0, c_ff}};
            rptr_in       = head_rd;
            rcls_in       = c_ff;
            state_in      = move_ff ? scpa_pkg::ST_GIVE : scpa_pkg::ST_FIN;
         end
         scpa_pkg::ST_GIVE: begin
            arena_wr.en   = 1'b1;
            arena_wr.addr = ptr_ff[19:3];
            arena_wr.data = {44'd0, head_rd};
            head_we       = 1'b1;
            head_wdata    = ptr_ff;
            if (move_ff) begin
               copy_in = (copy_min > 16'(scpa_pkg::COPY_CAP)) ? scpa_pkg::COPY_CAP
                                                              : copy_min[9:0];
            end
            state_in = scpa_pkg::ST_FIN;
         end
         scpa_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ptr_in   = rptr_ff;
               rsp_cls_in   = rcls_ff;
               rsp_copy_in  = copy_ff;
               rsp_st_in    = st_ff;
               state_in     = scpa_pkg::ST_IDLE;
            end
         end
         default: state_in = scpa_pkg::ST_IDLE;
      endcase
   end

   assign req_stall          = (state_ff != scpa_pkg::ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_pointer = rsp_ptr_ff;
   assign rsp_size_class     = rsp_cls_ff;
   assign rsp_copy_length    = rsp_copy_ff;
   assign rsp_status         = rsp_st_ff;

endmodule

@@ src/scpa_arena.sv @@
`timescale 1ns / 1ps
module scpa_arena (
   input  logic                           clock,
   input  scpa_pkg::arena_wr_type         wr,
   input  logic [scpa_pkg::ARENA_AW-1:0]  raddr,
   output logic [63:0]                    rdata
);

   logic [63:0] mem [0:(1 << scpa_pkg::ARENA_AW)-1];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/scpa_div.sv @@
`timescale 1ns / 1ps
module scpa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  scpa_pkg::div_req_type req,
   output logic                  done,
   output logic [16:0]           quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [10:0] rem_ff, rem_in;
   logic [16:0] q_ff, q_in;
   logic [9:0]  dvs_ff, dvs_in;
   logic [11:0] shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, q_ff[16]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(scpa_pkg::DIV_STEPS);
         rem_in  = '0;
         q_in    = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {2'b00, dvs_ff}) begin
            rem_in = 11'(shifted - {2'b00, dvs_ff});
            q_in   = {q_ff[15:0], 1'b1};
         end else begin
            rem_in = shifted[10:0];
            q_in   = {q_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ src/scpa_checker.sv @@
`timescale 1ns / 1ps
`include "size_class_pool_allocator_core_defines.svh"
module scpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [19:0] rsp_result_pointer,
   input logic [3:0]  rsp_size_class,
   input logic [1:0]  rsp_status
);

   `SCPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "not busy after accept")
   `SCPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_pointer), "stalled result changed")
   `SCPA_ASSERT_IMPL(a_fail_no_block, clock, reset, rsp_valid && rsp_status != scpa_pkg::STAT_OK, rsp_result_pointer == 20'd0 && rsp_size_class == scpa_pkg::NO_CLASS, "failed transaction returned a block")
   `SCPA_ASSERT_IMPL(a_ptr_aligned, clock, reset, rsp_valid && rsp_result_pointer != 20'd0, rsp_result_pointer[2:0] == 3'd0 && rsp_size_class != scpa_pkg::NO_CLASS, "bad block returned")

endmodule

bind size_class_pool_allocator_core scpa_checker u_scpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_pointer (rsp_result_pointer),
   .rsp_size_class     (rsp_size_class),
   .rsp_status         (rsp_status)
);

@@ bench/size_class_pool_allocator_core_tb.sv @@
`timescale 1ns / 1ps
module size_class_pool_allocator_core_tb;
   import scpa_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int ARENA_WORDS = 131072;
   localparam logic [16:0] SLAB_MIN = 17'd528;
   localparam logic [16:0] SLAB_MAX = 17'd65536;

   typedef struct {
      logic [19:0] ptr;
      logic [3:0]  cls;
      logic [9:0]  copy;
      status_type  st;
   } alloc_result_t;

   typedef struct {
      mode_type      mode;
      logic [19:0]   ptr;
      bit            ptr_last;
      logic [15:0]   size;
      bit            typed;
      alloc_result_t res;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [19:0] req_pointer;
   logic [15:0] req_request_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [19:0] rsp_result_pointer;
   logic [3:0]  rsp_size_class;
   logic [9:0]  rsp_copy_length;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_slab_bytes;

   // predictor state
   logic [63:0] arena_mem [int];
   int          touched_words[$];
   logic [19:0] list_head [12];
   logic [20:0] bump_ptr;
   logic [16:0] slab_size;

   alloc_result_t expected_q[$];
   logic [19:0]   live_ptrs[$];
   logic [19:0]   last_ptr;
   int            errors = 0;
   int            cycles = 0;
   int            sent = 0;
   int            checked = 0;
   int            refills = 0;
   int            exhausted_seen = 0;
   int            burst_left = 0;
   bit            no_gaps = 0;
   bit            hold_req = 0;

   size_class_pool_allocator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_pointer(req_pointer), .req_request_size(req_request_size),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_pointer(rsp_result_pointer), .rsp_size_class(rsp_size_class),
      .rsp_copy_length(rsp_copy_length), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_slab_bytes(csr_slab_bytes)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [20:0] block_bytes(int c);
      int sizes[12] = '{16, 24, 32, 48, 64, 96, 128, 160, 192, 256, 384, 512};
      return 21'(sizes[c]);
   endfunction

   function automatic int class_for_size(logic [15:0] n);
      for (int i = 0; i < CLASS_COUNT; i++) begin
         if ({5'd0, n} <= block_bytes(i)) return i;
      end
      return -1;
   endfunction

   function automatic logic [63:0] arena_rd(logic [20:0] addr);
      int w;
      w = int'(addr >> 3);
      if (w >= ARENA_WORDS) return 64'd0;
      return arena_mem.exists(w) ? arena_mem[w] : 64'd0;
   endfunction

   function automatic void arena_wr(logic [20:0] addr, logic [63:0] v);
      int w;
      w = int'(addr >> 3);
      if (w >= ARENA_WORDS) return;
      if (!arena_mem.exists(w)) touched_words.push_back(w);
      arena_mem[w] = v;
   endfunction

   function automatic bit refill_class(int c);
      logic [20:0] stride;
      logic [20:0] count;
      logic [20:0] need;
      logic [20:0] h;
      stride = 21'd8 + block_bytes(c);
      count = {4'd0, slab_size} / stride;
      if (count < 1) count = 1;
      need = count * stride;
      if (bump_ptr > ARENA_END || need > ARENA_END - bump_ptr) return 1'b0;
      for (int i = 0; i < int'(count); i++) begin
         h = bump_ptr + 21'(i) * stride;
         arena_wr(h, {32'd0, TAG_MAGIC | 32'(c)});
         arena_wr(h + 21'd8, {44'd0, list_head[c]});
         list_head[c] = 20'(h + 21'd8);
      end
      bump_ptr = bump_ptr + need;
      refills++;
      return 1'b1;
   endfunction

   function automatic status_type take_block(logic [15:0] n, ref alloc_result_t r);
      int c;
      logic [19:0] u;
      r.ptr = '0;
      r.cls = NO_CLASS;
      if (n == 0) n = 16'd1;
      c = class_for_size(n);
      if (c < 0) return STAT_BIG;
      if (list_head[c] == 0 && !refill_class(c)) return STAT_EXHAUSTED;
      u = list_head[c];
      list_head[c] = arena_rd({1'b0, u})[19:0];
      arena_wr({1'b0, u} - 21'd8, {16'd0, n, TAG_MAGIC | 32'(c)});
      r.ptr = u;
      r.cls = 4'(c);
      return STAT_OK;
   endfunction

   function automatic int owning_class(logic [19:0] p);
      logic [31:0] tag;
      if (p < 8 || p[2:0] != 3'd0) return -1;
      tag = arena_rd({1'b0, p} - 21'd8)[31:0];
      if ((tag & TAG_MASK) != TAG_MAGIC) return -1;
      if (tag[7:0] >= CLASS_COUNT) return -1;
      return int'(tag[7:0]);
   endfunction

   function automatic void push_free(logic [19:0] p, int c);
      arena_wr({1'b0, p}, {44'd0, list_head[c]});
      list_head[c] = p;
   endfunction

   function automatic alloc_result_t predict_alloc(mode_type m, logic [19:0] p,
                                                   logic [15:0] n);
      alloc_result_t r;
      int oc;
      int nc;
      logic [31:0] old_size;
      logic [63:0] hdr;
      r = '{ptr: '0, cls: NO_CLASS, copy: '0, st: STAT_OK};
      if (m == MODE_ALLOC || (m == MODE_REALLOC && p == 0)) begin
         r.st = take_block(n, r);
      end else if (m == MODE_FREE || (m == MODE_REALLOC && n == 0)) begin
         if (p != 0) begin
            oc = owning_class(p);
            if (oc < 0) r.st = STAT_FOREIGN;
            else push_free(p, oc);
         end
      end else if (m == MODE_REALLOC) begin
         oc = owning_class(p);
         if (oc < 0) begin
            r.st = STAT_FOREIGN;
         end else begin
            nc = class_for_size(n);
            hdr = arena_rd({1'b0, p} - 21'd8);
            if (nc == oc) begin
               arena_wr({1'b0, p} - 21'd8, {16'd0, n, hdr[31:0]});
               r.ptr = p;
               r.cls = 4'(oc);
            end else if (nc < 0) begin
               r.st = STAT_BIG;
            end else begin
               old_size = hdr[63:32];
               r.st = take_block(n, r);
               if (r.st == STAT_OK) begin
                  old_size = (old_size < {16'd0, n}) ? old_size : {16'd0, n};
                  if (old_size > 32'(COPY_CAP)) old_size = 32'(COPY_CAP);
                  r.copy = old_size[9:0];
                  push_free(p, oc);
               end
            end
         end
      end
      return r;
   endfunction

   task automatic send_request(mode_type m, logic [19:0] p, logic [15:0] n, bit typed,
                               alloc_result_t typed_res);
      alloc_result_t e;
      req_valid <= 1'b1;
      req_mode <= m;
      req_pointer <= p;
      req_request_size <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = predict_alloc(m, p, n);
      if (e.st == STAT_EXHAUSTED) exhausted_seen++;
      if (e.ptr != 0) begin
         last_ptr = e.ptr;
         live_ptrs.push_back(e.ptr);
         if (live_ptrs.size() > 400) void'(live_ptrs.pop_front());
      end
      expected_q.push_back(typed ? typed_res : e);
      sent++;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_slab(logic [16:0] v);
      csr_valid <= 1'b1;
      csr_slab_bytes <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      slab_size = v;
      @(posedge clock);
   endtask

   function automatic logic [19:0] choose_pointer(mode_type m);
      int r;
      int idx;
      logic [19:0] p;
      r = $urandom_range(0, 99);
      if (r < 60 && live_ptrs.size() > 0) begin
         idx = $urandom_range(0, live_ptrs.size() - 1);
         p = live_ptrs[idx];
         if (m == MODE_FREE && $urandom_range(0, 9) != 0) live_ptrs.delete(idx);
         return p;
      end
      if (r < 75 && touched_words.size() > 0) begin
         idx = $urandom_range(0, touched_words.size() - 1);
         return 20'((touched_words[idx] << 3) + 8);
      end
      if (r < 82) return 20'($urandom_range(1, 7));
      if (r < 88) return {17'($urandom_range(1, 131071)), 3'($urandom_range(1, 7))};
      return 20'd0;
   endfunction

   function automatic logic [15:0] choose_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'd0;
      if (r < 22) return 16'(block_bytes($urandom_range(0, 11))) + 16'($urandom_range(0, 1));
      if (r < 30) return ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(513, 65535));
      return 16'($urandom_range(1, 512));
   endfunction

   task automatic random_requests(int count);
      int r;
      mode_type m;
      alloc_result_t none;
      none = '{ptr: '0, cls: NO_CLASS, copy: '0, st: STAT_OK};
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         m = (r < 42) ? MODE_ALLOC : (r < 70) ? MODE_FREE : (r < 96) ? MODE_REALLOC : MODE_NONE;
         if (m == MODE_NONE) send_request(m, 20'($urandom), 16'($urandom), 1'b0, none);
         else if (m == MODE_ALLOC) send_request(m, 20'($urandom), choose_size(), 1'b0, none);
         else send_request(m, choose_pointer(m), choose_size(), 1'b0, none);
      end
   endtask

   stim_row_t directed[] = '{
      '{MODE_ALLOC, 20'd0, 1'b0, 16'd0, 1'b1,
        '{ptr: 20'd16360, cls: 4'd0, copy: 10'd0, st: STAT_OK}},
      '{MODE_ALLOC, 20'd0, 1'b0, 16'd512, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_ALLOC, 20'd0, 1'b0, 16'd513, 1'b1, '{'0, NO_CLASS, '0, STAT_BIG}},
      '{MODE_ALLOC, 20'd0, 1'b0, 16'hFFFF, 1'b1, '{'0, NO_CLASS, '0, STAT_BIG}},
      '{MODE_FREE, 20'd0, 1'b0, 16'd0, 1'b1, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_FREE, 20'd4, 1'b0, 16'd0, 1'b1, '{'0, NO_CLASS, '0, STAT_FOREIGN}},
      '{MODE_FREE, 20'd12, 1'b0, 16'd0, 1'b1, '{'0, NO_CLASS, '0, STAT_FOREIGN}},
      '{MODE_NONE, 20'hFFFFF, 1'b0, 16'hFFFF, 1'b1, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd0, 1'b0, 16'd24, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd0, 1'b1, 16'd20, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd0, 1'b1, 16'd200, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd0, 1'b1, 16'd600, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd0, 1'b1, 16'd0, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_FREE, 20'd0, 1'b1, 16'd0, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_ALLOC, 20'd0, 1'b0, 16'd384, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_FREE, 20'd16368, 1'b0, 16'd0, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_REALLOC, 20'd16360, 1'b0, 16'd16, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}},
      '{MODE_ALLOC, 20'd0, 1'b0, 16'd1, 1'b0, '{'0, NO_CLASS, '0, STAT_OK}}
   };

   // response checker
   always @(posedge clock) begin
      alloc_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected transaction: pointer %0d status %0d",
                   rsp_result_pointer, rsp_status);
            errors++;
         end else begin
            e = expected_q.pop_front();
            checked++;
            if (rsp_result_pointer !== e.ptr) begin
               $error("result_pointer: expected %0d, actual %0d", e.ptr, rsp_result_pointer);
               errors++;
            end
            if (rsp_size_class !== e.cls) begin
               $error("size_class: expected %0d, actual %0d", e.cls, rsp_size_class);
               errors++;
            end
            if (rsp_copy_length !== e.copy) begin
               $error("copy_length: expected %0d, actual %0d", e.copy, rsp_copy_length);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $error("status: expected %0d, actual %0d", e.st, rsp_status);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   initial begin
      int pattern;
      int phase_left;
      pattern = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_req = 0;
            rsp_stall <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               pattern = $urandom_range(0, 3);
               phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            case (pattern)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= phase_left[0];
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [19:0] p;
      alloc_result_t none;
      none = '{ptr: '0, cls: NO_CLASS, copy: '0, st: STAT_OK};
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_ALLOC;
      req_pointer = '0;
      req_request_size = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_slab_bytes = SLAB_RESET;
      for (int i = 0; i < CLASS_COUNT; i++) list_head[i] = '0;
      bump_ptr = BUMP_RESET;
      slab_size = SLAB_RESET;
      last_ptr = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         p = directed[i].ptr_last ? last_ptr : directed[i].ptr;
         send_request(directed[i].mode, p, directed[i].size, directed[i].typed,
                      directed[i].typed ? directed[i].res : none);
      end

      random_requests(120);
      // long receiver hold while requests keep coming
      hold_req = 1;
      no_gaps = 1;
      random_requests(12);
      no_gaps = 0;
      random_requests(80);
      drain_results();

      write_slab(SLAB_MIN);
      random_requests(200);
      drain_results();

      write_slab(17'($urandom_range(529, 65535)));
      random_requests(100);
      drain_results();

      write_slab(SLAB_MAX);
      random_requests(150);
      // run the largest class dry until the arena is exhausted
      for (int i = 0; i < 2500 && exhausted_seen < 3; i++) begin
         send_request(MODE_ALLOC, '0, 16'd512, 1'b0, none);
      end
      random_requests(120);
      drain_results();

      repeat (50) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d slab refills, %0d exhausted",
               sent, checked, refills, exhausted_seen);
      $display("slab sizes 528 to 65536, final bump pointer %0d", bump_ptr);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, expected_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
